// ===== src/mdu_pkg.sv =====
// mips multiply/divide unit package: operation codes, widths, stage payload type
// no dependencies
package mdu_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned BitsPerStage = 4;
  localparam int unsigned DivStages = DivSteps / BitsPerStage;

  typedef enum logic [1:0] {
    OP_MULT  = 2'd0,
    OP_MULTU = 2'd1,
    OP_DIV   = 2'd2,
    OP_DIVU  = 2'd3
  } op_t;

  typedef struct packed {
    logic       is_div;
    logic       special;
    logic       neg_q;
    logic       neg_r;
    logic [31:0] spec_hi;
    logic [31:0] spec_lo;
  } ctl_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvs;
  } div_t;

  typedef struct packed {
    logic [31:0] p_ll;
    logic [31:0] p_lh;
    logic [31:0] p_hl;
    logic [31:0] p_hh;
    logic        neg;
  } mul_t;

endpackage

// ===== src/mdu_front.sv =====
// operand preparation: magnitudes, special cases, 16x16 partial products
// depends on mdu_pkg
module mdu_front (
  input  logic               clk,
  input  logic               en,
  input  logic [1:0]         req_type,
  input  logic [31:0]        operand_a,
  input  logic [31:0]        operand_b,
  output mdu_pkg::ctl_t      ctl,
  output mdu_pkg::div_t      dv,
  output mdu_pkg::mul_t      ml
);

  logic        sgn;
  logic        na;
  logic        nb;
  logic [31:0] ma;
  logic [31:0] mb;
  mdu_pkg::ctl_t ctl_next;

  always_comb begin
    sgn = (req_type == mdu_pkg::OP_MULT) || (req_type == mdu_pkg::OP_DIV);
    na = sgn && operand_a[31];
    nb = sgn && operand_b[31];
    ma = na ? (32'd0 - operand_a) : operand_a;
    mb = nb ? (32'd0 - operand_b) : operand_b;
    ctl_next.is_div = req_type[1];
    ctl_next.special = (operand_b == 32'd0);
    ctl_next.neg_q = na ^ nb;
    ctl_next.neg_r = na;
    ctl_next.spec_hi = operand_a;
    ctl_next.spec_lo = 32'hFFFF_FFFF;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_next;
      dv.rem <= 32'd0;
      dv.quo <= ma;
      dv.dvs <= mb;
      ml.p_ll <= ma[15:0] * mb[15:0];
      ml.p_lh <= ma[15:0] * mb[31:16];
      ml.p_hl <= ma[31:16] * mb[15:0];
      ml.p_hh <= ma[31:16] * mb[31:16];
      ml.neg <= na ^ nb;
    end
  end

endmodule

// ===== src/mdu_div_stage.sv =====
// one restoring-division stage, several quotient bits; multiply payload passes along
// depends on mdu_pkg
module mdu_div_stage (
  input  logic          clk,
  input  logic          en,
  input  mdu_pkg::ctl_t ctl_in,
  input  mdu_pkg::div_t dv_in,
  input  mdu_pkg::mul_t ml_in,
  output mdu_pkg::ctl_t ctl,
  output mdu_pkg::div_t dv,
  output mdu_pkg::mul_t ml
);

  mdu_pkg::div_t d;
  logic [32:0]   trial;

  always_comb begin
    d = dv_in;
    trial = 33'd0;
    for (int i = 0; i < mdu_pkg::BitsPerStage; i++) begin
      trial = {d.rem, d.quo[31]} - {1'b0, d.dvs};
      if (!trial[32]) begin
        d.rem = trial[31:0];
        d.quo = {d.quo[30:0], 1'b1};
      end else begin
        d.rem = {d.rem[30:0], d.quo[31]};
        d.quo = {d.quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl <= ctl_in;
      dv <= d;
      ml <= ml_in;
    end
  end

endmodule

// ===== src/mdu_back.sv =====
// result stage: product sum and sign, quotient/remainder sign, special cases
// depends on mdu_pkg
module mdu_back (
  input  logic          clk,
  input  logic          en,
  input  mdu_pkg::ctl_t ctl_in,
  input  mdu_pkg::div_t dv_in,
  input  mdu_pkg::mul_t ml_in,
  output logic [31:0]   hi_word,
  output logic [31:0]   lo_word
);

  logic [63:0] prod;
  logic [63:0] sprod;
  logic [31:0] q;
  logic [31:0] r;
  logic [31:0] hi_next;
  logic [31:0] lo_next;

  always_comb begin
    prod = {ml_in.p_hh, ml_in.p_ll}
         + {16'd0, ml_in.p_lh, 16'd0}
         + {16'd0, ml_in.p_hl, 16'd0};
    sprod = ml_in.neg ? (64'd0 - prod) : prod;
    q = ctl_in.neg_q ? (32'd0 - dv_in.quo) : dv_in.quo;
    r = ctl_in.neg_r ? (32'd0 - dv_in.rem) : dv_in.rem;
    if (!ctl_in.is_div) begin
      hi_next = sprod[63:32];
      lo_next = sprod[31:0];
    end else if (ctl_in.special) begin
      hi_next = ctl_in.spec_hi;
      lo_next = ctl_in.spec_lo;
    end else begin
      hi_next = r;
      lo_next = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_word <= hi_next;
      lo_word <= lo_next;
    end
  end

endmodule

// ===== src/mips_multiply_divide_unit.sv =====
// Pipelined multiply/divide unit. One operation is accepted per cycle while the
// output is not stalled; each result is offered after passing through ten register
// stages (front stage, 8 divide stages of 4 quotient bits each, result stage).
// A stall on the output freezes the whole pipeline; tready on the input
// follows the output side so nothing is lost. Input tdata: req_type[1:0],
// operand_a[33:2], operand_b[65:34]. Output tdata: hi_word[31:0], lo_word[63:32].
// depends on mdu_pkg, mdu_front, mdu_div_stage and mdu_back
module mips_multiply_divide_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // req_type, operand_a, operand_b, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // hi_word, lo_word
);

  localparam int unsigned NumStages = mdu_pkg::DivStages + 2;

  logic [NumStages-1:0] vld;
  logic                 en;

  mdu_pkg::ctl_t ctl [mdu_pkg::DivStages+1];
  mdu_pkg::div_t dv  [mdu_pkg::DivStages+1];
  mdu_pkg::mul_t ml  [mdu_pkg::DivStages+1];

  assign en = m_tready || !vld[NumStages-1];
  assign s_tready = en;
  assign m_tvalid = vld[NumStages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NumStages-2:0], s_tvalid};
    end
  end

  mdu_front u_front (
    .clk(clk), .en(en),
    .req_type(s_tdata[1:0]), .operand_a(s_tdata[33:2]), .operand_b(s_tdata[65:34]),
    .ctl(ctl[0]), .dv(dv[0]), .ml(ml[0])
  );

  for (genvar g = 0; g < mdu_pkg::DivStages; g++) begin : g_div
    mdu_div_stage u_stage (
      .clk(clk), .en(en),
      .ctl_in(ctl[g]), .dv_in(dv[g]), .ml_in(ml[g]),
      .ctl(ctl[g+1]), .dv(dv[g+1]), .ml(ml[g+1])
    );
  end

  mdu_back u_back (
    .clk(clk), .en(en),
    .ctl_in(ctl[mdu_pkg::DivStages]), .dv_in(dv[mdu_pkg::DivStages]),
    .ml_in(ml[mdu_pkg::DivStages]),
    .hi_word(m_tdata[31:0]), .lo_word(m_tdata[63:32])
  );

endmodule
